/* hw/rtl/dboc_pkg.sv */
// shared constants for the debounced occupancy counter
// no dependencies
package dboc_pkg;

    localparam int SENSOR_COUNT       = 8;
    localparam int DIR_COUNT          = 4;
    localparam int DEBOUNCE_BITS      = 16;
    localparam int TOTAL_BITS         = 16;
    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int COUNT_BITS_DEFAULT = 16;

    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd50;

endpackage

/* hw/rtl/debounced_occupancy_counter.sv */
// debounced occupancy counter top level: eight debounced beam sensors feeding four counts
// depends on dboc_pkg
//
//  channel | beat                          | handshake
//  --------+-------------------------------+----------------------------
//  in      | eight raw sensor levels       | in_valid / in_stall
//  out     | four direction totals         | out_valid / out_stall
//  cfg     | debounce_ms                   | cfg_we / cfg_wdata
//
// one beat a cycle sustained while out_stall is low; an input beat passes through the
// input register, then a single pass of timers, compares and count adders into the
// result register
// reset clears levels, quiet timers and counts to zero and debounce_ms to 50
// a stalled result holds the pipe; a new input beat is still taken while the
// input register is empty, so the input side sees one beat of slack
module debounced_occupancy_counter
#(
    parameter int TIMER_BITS = dboc_pkg::TIMER_BITS_DEFAULT,
    parameter int COUNT_BITS = dboc_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [dboc_pkg::DEBOUNCE_BITS-1:0] cfg_wdata,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              north_entry,
    input  logic                              north_exit,
    input  logic                              south_entry,
    input  logic                              south_exit,
    input  logic                              east_entry,
    input  logic                              east_exit,
    input  logic                              west_entry,
    input  logic                              west_exit,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dboc_pkg::TOTAL_BITS-1:0]    north_total,
    output logic [dboc_pkg::TOTAL_BITS-1:0]    south_total,
    output logic [dboc_pkg::TOTAL_BITS-1:0]    east_total,
    output logic [dboc_pkg::TOTAL_BITS-1:0]    west_total
);
    import dboc_pkg::*;

    // compare width covers both the timer and the debounce setting
    localparam int CMP_BITS = (TIMER_BITS > DEBOUNCE_BITS) ? TIMER_BITS : DEBOUNCE_BITS;
    // output width covers both the count and the result field
    localparam int EXT_BITS = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration
    logic [DEBOUNCE_BITS-1:0] debounce_reg;

    // input register
    logic                    in_valid_reg;
    logic [SENSOR_COUNT-1:0] raw_reg;

    // per-sensor and per-direction state
    logic [SENSOR_COUNT-1:0] prev_raw_reg;
    logic [SENSOR_COUNT-1:0] prev_raw_next;
    logic [SENSOR_COUNT-1:0] stable_reg;
    logic [SENSOR_COUNT-1:0] stable_next;
    logic [TIMER_BITS-1:0]   timer_reg  [SENSOR_COUNT];
    logic [TIMER_BITS-1:0]   timer_next [SENSOR_COUNT];
    logic [COUNT_BITS-1:0]   total_reg  [DIR_COUNT];
    logic [COUNT_BITS-1:0]   total_next [DIR_COUNT];

    // result register
    logic                  out_valid_reg;
    logic [TOTAL_BITS-1:0] result_reg [DIR_COUNT];

    logic                    advance;
    logic                    in_take;
    logic [SENSOR_COUNT-1:0] edge_hit;

    // the pipe moves when the result slot is free or being emptied
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // debounce: timers, stability compare and rising-edge detect, all sensors side by side
    always_comb
    begin
        logic [CMP_BITS-1:0] quiet;
        logic [CMP_BITS-1:0] limit;
        logic                settled;
        limit = CMP_BITS'(debounce_reg);
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            if (raw_reg[i] != prev_raw_reg[i])
            begin
                timer_next[i] = '0;
            end
            else if (timer_reg[i] != TIMER_MAX)
            begin
                timer_next[i] = timer_reg[i] + TIMER_BITS'(1);
            end
            else
            begin
                timer_next[i] = timer_reg[i];
            end
            prev_raw_next[i] = raw_reg[i];
            quiet            = CMP_BITS'(timer_next[i]);
            settled          = (quiet >= limit);
            edge_hit[i]      = settled && raw_reg[i] && !stable_reg[i];
            stable_next[i]   = settled ? raw_reg[i] : stable_reg[i];
        end
    end

    // counts: entry edge first, then exit edge, both saturating
    always_comb
    begin
        logic [COUNT_BITS-1:0] after_entry;
        for (int d = 0; d < DIR_COUNT; d++)
        begin
            after_entry = total_reg[d];
            if (edge_hit[2*d] && (total_reg[d] != COUNT_MAX))
            begin
                after_entry = total_reg[d] + COUNT_BITS'(1);
            end
            total_next[d] = after_entry;
            if (edge_hit[2*d+1] && (after_entry != '0))
            begin
                total_next[d] = after_entry - COUNT_BITS'(1);
            end
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= cfg_wdata;
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_valid_reg || advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input payload, sensor order north, south, east, west with entry below exit
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            raw_reg <= {west_exit, west_entry, east_exit, east_entry,
                        south_exit, south_entry, north_exit, north_entry};
        end
    end

    // sensor and count state, updated once per beat leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= '0;
            stable_reg   <= '0;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                timer_reg[i] <= '0;
            end
            for (int d = 0; d < DIR_COUNT; d++)
            begin
                total_reg[d] <= '0;
            end
        end
        else if (in_valid_reg && advance)
        begin
            prev_raw_reg <= prev_raw_next;
            stable_reg   <= stable_next;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                timer_reg[i] <= timer_next[i];
            end
            for (int d = 0; d < DIR_COUNT; d++)
            begin
                total_reg[d] <= total_next[d];
            end
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result payload, low bits of each count
    always_ff @(posedge clk)
    begin
        logic [EXT_BITS-1:0] wide;
        if (in_valid_reg && advance)
        begin
            for (int d = 0; d < DIR_COUNT; d++)
            begin
                wide          = EXT_BITS'(total_next[d]);
                result_reg[d] <= wide[TOTAL_BITS-1:0];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign north_total = result_reg[0];
    assign south_total = result_reg[1];
    assign east_total  = result_reg[2];
    assign west_total  = result_reg[3];

endmodule

/* dv/debounced_occupancy_counter_checker.sv */
// checker for the debounced occupancy counter: predicts the four totals per tick and
// compares them with every accepted result beat
// depends on dboc_pkg
module debounced_occupancy_counter_checker
#(
    parameter int TIMER_BITS = dboc_pkg::TIMER_BITS_DEFAULT,
    parameter int COUNT_BITS = dboc_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dboc_pkg::DEBOUNCE_BITS-1:0] cfg_wdata,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               north_entry,
    input  logic                               north_exit,
    input  logic                               south_entry,
    input  logic                               south_exit,
    input  logic                               east_entry,
    input  logic                               east_exit,
    input  logic                               west_entry,
    input  logic                               west_exit,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [dboc_pkg::TOTAL_BITS-1:0]    north_total,
    input  logic [dboc_pkg::TOTAL_BITS-1:0]    south_total,
    input  logic [dboc_pkg::TOTAL_BITS-1:0]    east_total,
    input  logic [dboc_pkg::TOTAL_BITS-1:0]    west_total,
    output int                                 mismatch_count,
    output int                                 pending_beats
);

    timeunit 1ns;
    timeprecision 1ps;

    import dboc_pkg::*;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] north;
        logic [TOTAL_BITS-1:0] south;
        logic [TOTAL_BITS-1:0] east;
        logic [TOTAL_BITS-1:0] west;
    } totals_t;

    localparam logic [TIMER_BITS-1:0] QUIET_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int REPORT_LIMIT = 10;

    logic [DEBOUNCE_BITS-1:0] debounce_ms;
    logic [SENSOR_COUNT-1:0]  last_raw;
    logic [SENSOR_COUNT-1:0]  steady;
    logic [TIMER_BITS-1:0]    quiet [SENSOR_COUNT];
    logic [COUNT_BITS-1:0]    occupancy [DIR_COUNT];
    totals_t                  totals_due [$];
    int                       mismatches;

    // one tick of all eight sensors, entry before exit within a direction
    task automatic tick_sensors(input logic [SENSOR_COUNT-1:0] raw);
        int      dir;
        totals_t due;
        logic [TOTAL_BITS-1:0] low_bits [DIR_COUNT];
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            if (raw[i] != last_raw[i])
                quiet[i] = '0;
            else if (quiet[i] != QUIET_MAX)
                quiet[i] = quiet[i] + 1'b1;
            last_raw[i] = raw[i];
            if (quiet[i] >= debounce_ms)
            begin
                if (raw[i] && !steady[i])
                begin
                    dir = i / 2;
                    if (i % 2 == 1)
                    begin
                        if (occupancy[dir] != '0)
                            occupancy[dir] = occupancy[dir] - 1'b1;
                    end
                    else if (occupancy[dir] != COUNT_MAX)
                        occupancy[dir] = occupancy[dir] + 1'b1;
                end
                steady[i] = raw[i];
            end
        end
        for (int d = 0; d < DIR_COUNT; d++)
            low_bits[d] = occupancy[d];
        due.north = low_bits[0];
        due.south = low_bits[1];
        due.east  = low_bits[2];
        due.west  = low_bits[3];
        totals_due.push_back(due);
    endtask

    task automatic check_beat();
        totals_t want;
        totals_t got;
        got = {north_total, south_total, east_total, west_total};
        if (totals_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: result beat with nothing due: n=%0d s=%0d e=%0d w=%0d",
                         $realtime, got.north, got.south, got.east, got.west);
        end
        else
        begin
            want = totals_due.pop_front();
            if (got.north !== want.north || got.south !== want.south ||
                got.east !== want.east || got.west !== want.west)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"%0t: totals differ: want n=%0d s=%0d e=%0d w=%0d, ",
                              "got n=%0d s=%0d e=%0d w=%0d"},
                             $realtime, want.north, want.south, want.east, want.west,
                             got.north, got.south, got.east, got.west);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms = DEBOUNCE_RESET;
            last_raw    = '0;
            steady      = '0;
            for (int i = 0; i < SENSOR_COUNT; i++)
                quiet[i] = '0;
            for (int d = 0; d < DIR_COUNT; d++)
                occupancy[d] = '0;
            totals_due.delete();
            mismatches = 0;
            mismatch_count <= 0;
            pending_beats  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_beat();
            if (cfg_we)
                debounce_ms = cfg_wdata;
            if (in_valid && !in_stall)
                tick_sensors({west_exit, west_entry, east_exit, east_entry,
                              south_exit, south_entry, north_exit, north_entry});
            mismatch_count <= mismatches;
            pending_beats  <= totals_due.size();
        end
    end

endmodule

/* dv/debounced_occupancy_counter_tb.sv */
// testbench top for the debounced occupancy counter: reset, clock, tick stimulus,
// result-side stalls and the verdict
// depends on dboc_pkg, debounced_occupancy_counter and debounced_occupancy_counter_checker
module debounced_occupancy_counter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dboc_pkg::*;

    // latency through the block, plus a little margin before any register write
    localparam int PIPE_LATENCY = 2;
    localparam int SETTLE       = PIPE_LATENCY + 4;

    // idle percentages for the two stall regimes
    localparam int IDLE_LIGHT = 22;
    localparam int IDLE_HEAVY = 87;

    // sensor bit order: [0] north entry, [1] north exit, [2] south entry ... [7] west exit
    // 8'h55 is every entry sensor, 8'hAA every exit sensor
    // at the reset debounce of 50 ticks a short blip never becomes stable
    localparam logic [0:3][7:0] RESET_DEB_TICKS = {8'h00, 8'hFF, 8'hFF, 8'h00};
    // zero debounce: exits at zero stay at zero, entry and exit on the same tick at zero
    // must end at zero (entry first), plain entries, held levels, exits after entries
    localparam logic [0:12][7:0] ZERO_DEB_TICKS =
        {8'h00, 8'hAA, 8'h00, 8'hFF, 8'h00, 8'h55, 8'h55,
         8'h00, 8'h55, 8'hFF, 8'h00, 8'hFF, 8'h00};
    // one tick debounce: a one-tick glitch is rejected, a two-tick level counts
    localparam logic [0:7][7:0] ONE_DEB_TICKS =
        {8'h55, 8'h00, 8'h55, 8'h55, 8'h00, 8'h00, 8'hFF, 8'hFF};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     cfg_we = 1'b0;
    logic [DEBOUNCE_BITS-1:0] cfg_wdata = '0;

    logic in_valid = 1'b0;
    logic in_stall;
    logic north_entry = 1'b0;
    logic north_exit  = 1'b0;
    logic south_entry = 1'b0;
    logic south_exit  = 1'b0;
    logic east_entry  = 1'b0;
    logic east_exit   = 1'b0;
    logic west_entry  = 1'b0;
    logic west_exit   = 1'b0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [TOTAL_BITS-1:0] north_total;
    logic [TOTAL_BITS-1:0] south_total;
    logic [TOTAL_BITS-1:0] east_total;
    logic [TOTAL_BITS-1:0] west_total;

    int mismatch_count;
    int pending_beats;

    // current idle regime of the two sides, in percent of cycles
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // random level generator: present level and remaining run length per sensor
    logic [SENSOR_COUNT-1:0] sensor_level = '0;
    int                      run_left [SENSOR_COUNT];

    debounced_occupancy_counter u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .north_entry (north_entry),
        .north_exit  (north_exit),
        .south_entry (south_entry),
        .south_exit  (south_exit),
        .east_entry  (east_entry),
        .east_exit   (east_exit),
        .west_entry  (west_entry),
        .west_exit   (west_exit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .north_total (north_total),
        .south_total (south_total),
        .east_total  (east_total),
        .west_total  (west_total)
    );

    debounced_occupancy_counter_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .north_entry    (north_entry),
        .north_exit     (north_exit),
        .south_entry    (south_entry),
        .south_exit     (south_exit),
        .east_entry     (east_entry),
        .east_exit      (east_exit),
        .west_entry     (west_entry),
        .west_exit      (west_exit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .north_total    (north_total),
        .south_total    (south_total),
        .east_total     (east_total),
        .west_total     (west_total),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    // 8 ns clock period
    always #4 clk = ~clk;

    // result side stalls at random; one assignment per edge, independent of out_valid
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // hard stop, well above the slowest legal run under the heavy idle regimes
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // offer one tick beat, with random gaps first, and hold it until taken
    task automatic send_tick(input logic [SENSOR_COUNT-1:0] lv);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        north_entry <= lv[0];
        north_exit  <= lv[1];
        south_entry <= lv[2];
        south_exit  <= lv[3];
        east_entry  <= lv[4];
        east_exit   <= lv[5];
        west_entry  <= lv[6];
        west_exit   <= lv[7];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop sending and wait until every due result beat has come back
    // the first edge is always waited so the checker's count already includes the last beat
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats != 0);
    endtask

    // register writes only once the pipe is empty and settled
    task automatic write_debounce(input logic [DEBOUNCE_BITS-1:0] value);
        drain_results();
        repeat (SETTLE) @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // mostly well-formed presses: each level is held a little longer than the
    // debounce time, with one run in five cut short as a glitch, and now and
    // then a single-tick burst of noise on random sensors
    task automatic random_phase(input int n_items, input int run_base);
        logic [SENSOR_COUNT-1:0] lv;
        for (int k = 0; k < n_items; k++)
        begin
            for (int s = 0; s < SENSOR_COUNT; s++)
            begin
                if (run_left[s] <= 0)
                begin
                    sensor_level[s] = ~sensor_level[s];
                    if ($urandom_range(4) == 0)
                        run_left[s] = $urandom_range(1, (run_base > 1) ? run_base : 1);
                    else
                        run_left[s] = $urandom_range(run_base + 1, run_base + 4 + run_base / 2);
                end
                run_left[s]--;
            end
            lv = sensor_level;
            if ($urandom_range(19) == 0)
                lv = lv ^ SENSOR_COUNT'($urandom());
            send_tick(lv);
            // occasional full hold-off until the result side has caught up
            if ($urandom_range(199) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        for (int s = 0; s < SENSOR_COUNT; s++)
            run_left[s] = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, sender idling lightly and receiver heavily
        set_idling(IDLE_LIGHT, IDLE_HEAVY);
        for (int i = 0; i < 4; i++)
            send_tick(RESET_DEB_TICKS[i]);
        write_debounce(16'd0);
        for (int i = 0; i < 13; i++)
            send_tick(ZERO_DEB_TICKS[i]);
        write_debounce(16'd1);
        for (int i = 0; i < 8; i++)
            send_tick(ONE_DEB_TICKS[i]);

        // random part, first regime continued
        write_debounce(16'd3);
        random_phase(360, 3);
        write_debounce(16'd0);
        random_phase(360, 0);

        // regime swapped: sender mostly idle, receiver lightly
        set_idling(IDLE_HEAVY, IDLE_LIGHT);
        write_debounce(16'd7);
        random_phase(300, 7);
        write_debounce(16'd50);
        random_phase(350, 50);

        // no idling from here on
        set_idling(0, 0);
        // largest debounce: nothing can become stable within this phase
        write_debounce(16'hFFFF);
        random_phase(60, 10);
        write_debounce(16'd1);
        random_phase(60, 1);
        write_debounce(16'd0);
        random_phase(40, 0);

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && pending_beats == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
